@@ hw/rtl/ucb_pkg.sv @@
// ----------------------------------------------------------------------------
// UCB1 arm selector package
// Shared types and fixed constants for the arm selector and its divider.
// ----------------------------------------------------------------------------
package ucb_pkg;

    localparam int unsigned NUM_ARMS    = 16;
    localparam int unsigned ARM_W       = 4;
    localparam int unsigned CNT_W       = 32;
    localparam int unsigned SUM_W       = 48;
    localparam int unsigned REWARD_W    = 17;
    localparam int unsigned SCORE_W     = 20;
    localparam int unsigned LN_W        = 21;
    localparam int unsigned FRAC_W      = 16;
    localparam int unsigned STEP_W      = 6;
    localparam int unsigned RAD_W       = 38;

    localparam logic [REWARD_W-1:0] REWARD_ONE = REWARD_W'(65536);
    localparam logic [15:0]         LN2_Q16    = 16'd45426;
    localparam logic [SCORE_W-1:0]  SCORE_MAX  = '1;
    localparam logic [CNT_W-1:0]    CNT_MAX    = '1;
    localparam logic [SUM_W-1:0]    SUM_MAX    = '1;

    // Request kinds carried on the input tuser bit
    localparam logic REQ_SELECT = 1'b0;
    localparam logic REQ_UPDATE = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_NORM,
        ST_LOG,
        ST_LN,
        ST_ARM,
        ST_DIV_MEAN,
        ST_DIV_TERM,
        ST_SQRT,
        ST_SCORE,
        ST_OUT
    } state_t;

endpackage

@@ hw/rtl/ucb_div.sv @@
// ----------------------------------------------------------------------------
// UCB divider
// Restoring divider, one quotient bit per cycle, dividend MSB-aligned.
// ----------------------------------------------------------------------------
module ucb_div
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [ucb_pkg::SUM_W-1:0]        dividend,
    input  logic [ucb_pkg::CNT_W-1:0]        divisor,
    input  logic [ucb_pkg::STEP_W-1:0]       steps,
    output logic                             busy,
    output logic [ucb_pkg::SUM_W-1:0]        quotient
);

    logic [ucb_pkg::SUM_W-1:0]  q_reg;
    logic [ucb_pkg::CNT_W-1:0]  r_reg;
    logic [ucb_pkg::CNT_W-1:0]  d_reg;
    logic [ucb_pkg::STEP_W-1:0] cnt_reg;
    logic                       busy_reg;

    logic [ucb_pkg::CNT_W:0]    r_shift;
    logic [ucb_pkg::CNT_W:0]    r_diff;
    logic                       ge;

    assign r_shift = {r_reg, q_reg[ucb_pkg::SUM_W-1]};
    assign ge      = (r_shift >= {1'b0, d_reg});
    assign r_diff  = r_shift - {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= steps;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == ucb_pkg::STEP_W'(1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg <= {q_reg[ucb_pkg::SUM_W-2:0], ge};
            r_reg <= ge ? r_diff[ucb_pkg::CNT_W-1:0] : r_shift[ucb_pkg::CNT_W-1:0];
        end
    end

    assign busy     = busy_reg;
    assign quotient = q_reg;

endmodule

@@ hw/rtl/ucb1_arm_selector.sv @@
// ----------------------------------------------------------------------------
// UCB1 arm selector
// Keeps pull counts and reward sums per arm and picks the next arm to pull.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats arrive on s_t*: tuser is the request kind (select or update),
//   tdata carries arm_index and reward. An update beat is absorbed in the
//   cycle it is accepted and gives no result. A select beat gives one result
//   beat on m_t*: tdata holds chosen_arm, tuser is from_first_pass.
//   Write the arm count register on cfg_valid/cfg_ready only while idle; the block itself does not enforce it.
// Sequence:
//   Update: absorbed on acceptance. Select, first pass: scans up to the first unpulled arm.
//   Select by score: normalises the total, takes its log, then for each of the k arms
//   in use runs the shared divider (48 steps for the mean, 22 for the bonus term)
//   and the 19-step square root per arm, then scores it.
//   One request is in flight at a time; s_tready is low meanwhile.
// Reset:
//   All counts and sums clear, arm count returns to 16, no result pending.
// Stall:
//   The result sits in an output register; the next request is accepted
//   while it waits, and a second result holds until the first is taken.
// ----------------------------------------------------------------------------
module ucb1_arm_selector
(
    input  logic        clk,
    input  logic        rst_n,
    // Config: arms_in_use
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [3:0] arm_index, [20:4] reward, [23:21] zero
    input  logic        s_tuser,   // [0] req_type
    // Output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [3:0] chosen_arm, [7:4] zero
    output logic        m_tuser    // [0] from_first_pass
);

    localparam int unsigned AW = ucb_pkg::ARM_W;

    ucb_pkg::state_t state_reg, state_next;

    logic [4:0]                  arms_reg;
    logic [ucb_pkg::CNT_W-1:0]   pull_reg [ucb_pkg::NUM_ARMS];
    logic [ucb_pkg::SUM_W-1:0]   rsum_reg [ucb_pkg::NUM_ARMS];
    logic [ucb_pkg::CNT_W-1:0]   total_reg;

    logic [AW-1:0]               idx_reg, idx_next;
    logic [ucb_pkg::CNT_W-1:0]   x_reg, x_next;
    logic [4:0]                  top_reg, top_next;
    logic [30:0]                 y_reg, y_next;
    logic [ucb_pkg::FRAC_W-1:0]  frac_reg, frac_next;
    logic [3:0]                  it_reg, it_next;
    logic [ucb_pkg::LN_W-1:0]    ln_reg, ln_next;
    logic [ucb_pkg::SUM_W-1:0]   mean_reg, mean_next;
    logic [ucb_pkg::RAD_W-1:0]   rad_reg, rad_next;
    logic [ucb_pkg::RAD_W-1:0]   root_reg, root_next;
    logic [ucb_pkg::RAD_W-1:0]   bit_reg, bit_next;
    logic [ucb_pkg::SCORE_W-1:0] best_reg, best_next;
    logic [AW-1:0]               best_idx_reg, best_idx_next;
    logic [AW-1:0]               pend_arm_reg, pend_arm_next;
    logic                        pend_first_reg, pend_first_next;

    logic                        m_valid_reg;
    logic [AW-1:0]               chosen_reg;
    logic                        first_reg;

    // Effective arm count and request decode
    logic [4:0]                  k_eff;
    logic                        last_arm;
    logic                        in_fire;
    logic                        out_load;
    logic [AW-1:0]               in_arm;
    logic [ucb_pkg::REWARD_W-1:0] in_reward;
    logic [ucb_pkg::REWARD_W-1:0] rew_clamp;
    logic                        upd_fire;

    // Shared arithmetic
    logic [61:0]                 sq_prod;
    logic [31:0]                 sq_shift;
    logic [36:0]                 ln_prod;
    logic [ucb_pkg::RAD_W-1:0]   root_trial;
    logic [ucb_pkg::SUM_W:0]     score_sum;
    logic [ucb_pkg::SCORE_W-1:0] score;
    logic [ucb_pkg::CNT_W-1:0]   cur_cnt;

    logic                        div_start;
    logic [ucb_pkg::SUM_W-1:0]   div_dividend;
    logic [ucb_pkg::STEP_W-1:0]  div_steps;
    logic                        div_busy;
    logic [ucb_pkg::SUM_W-1:0]   div_q;

    assign k_eff = (arms_reg == 5'd0) ? 5'd1 :
                   (arms_reg > 5'(ucb_pkg::NUM_ARMS)) ? 5'(ucb_pkg::NUM_ARMS) : arms_reg;
    assign last_arm  = ({1'b0, idx_reg} == (k_eff - 5'd1));

    assign in_arm    = s_tdata[3:0];
    assign in_reward = s_tdata[20:4];
    assign rew_clamp = (in_reward > ucb_pkg::REWARD_ONE) ? ucb_pkg::REWARD_ONE : in_reward;

    assign s_tready  = (state_reg == ucb_pkg::ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign upd_fire  = in_fire && (s_tuser == ucb_pkg::REQ_UPDATE) && ({1'b0, in_arm} < k_eff);
    assign cfg_ready = 1'b1;

    assign out_load  = (state_reg == ucb_pkg::ST_OUT) && (!m_valid_reg || m_tready);

    assign cur_cnt    = (pull_reg[idx_reg] == '0) ? ucb_pkg::CNT_W'(1) : pull_reg[idx_reg];
    assign sq_prod    = {31'd0, y_reg} * {31'd0, y_reg};
    assign sq_shift   = sq_prod[61:30];
    assign ln_prod    = {top_reg, frac_reg} * ucb_pkg::LN2_Q16;
    assign root_trial = root_reg + bit_reg;
    assign score_sum  = {1'b0, mean_reg} + {11'd0, root_reg};
    assign score      = (score_sum > {29'd0, ucb_pkg::SCORE_MAX}) ? ucb_pkg::SCORE_MAX
                                                                  : score_sum[ucb_pkg::SCORE_W-1:0];

    ucb_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (cur_cnt),
        .steps    (div_steps),
        .busy     (div_busy),
        .quotient (div_q)
    );

    // Sequencer: next state and datapath
    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        x_next          = x_reg;
        top_next        = top_reg;
        y_next          = y_reg;
        frac_next       = frac_reg;
        it_next         = it_reg;
        ln_next         = ln_reg;
        mean_next       = mean_reg;
        rad_next        = rad_reg;
        root_next       = root_reg;
        bit_next        = bit_reg;
        best_next       = best_reg;
        best_idx_next   = best_idx_reg;
        pend_arm_next   = pend_arm_reg;
        pend_first_next = pend_first_reg;
        div_start       = 1'b0;
        div_dividend    = rsum_reg[idx_reg];
        div_steps       = ucb_pkg::STEP_W'(ucb_pkg::SUM_W);

        unique case (state_reg)
            ucb_pkg::ST_IDLE:
            begin
                if (in_fire && (s_tuser == ucb_pkg::REQ_SELECT))
                begin
                    idx_next   = '0;
                    state_next = ucb_pkg::ST_SCAN;
                end
            end
            ucb_pkg::ST_SCAN:
            begin
                // Lowest unpulled arm wins outright
                if (pull_reg[idx_reg] == '0)
                begin
                    pend_arm_next   = idx_reg;
                    pend_first_next = 1'b1;
                    state_next      = ucb_pkg::ST_OUT;
                end
                else if (last_arm)
                begin
                    x_next     = total_reg;
                    top_next   = 5'd31;
                    state_next = ucb_pkg::ST_NORM;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ucb_pkg::ST_NORM:
            begin
                // Shift until the top bit is set; total is at least one here
                if (x_reg[ucb_pkg::CNT_W-1])
                begin
                    y_next     = x_reg[31:1];
                    frac_next  = '0;
                    it_next    = '0;
                    state_next = ucb_pkg::ST_LOG;
                end
                else
                begin
                    x_next   = {x_reg[30:0], 1'b0};
                    top_next = top_reg - 1'b1;
                end
            end
            ucb_pkg::ST_LOG:
            begin
                if (sq_shift[31])
                begin
                    y_next    = sq_shift[31:1];
                    frac_next = {frac_reg[14:0], 1'b1};
                end
                else
                begin
                    y_next    = sq_shift[30:0];
                    frac_next = {frac_reg[14:0], 1'b0};
                end
                it_next = it_reg + 1'b1;
                if (it_reg == 4'd15)
                    state_next = ucb_pkg::ST_LN;
            end
            ucb_pkg::ST_LN:
            begin
                ln_next    = ln_prod[36:16];
                idx_next   = '0;
                state_next = ucb_pkg::ST_ARM;
            end
            ucb_pkg::ST_ARM:
            begin
                div_start  = 1'b1;
                state_next = ucb_pkg::ST_DIV_MEAN;
            end
            ucb_pkg::ST_DIV_MEAN:
            begin
                if (!div_busy)
                begin
                    mean_next    = div_q;
                    div_start    = 1'b1;
                    div_dividend = {ln_reg, 1'b0, 26'd0};
                    div_steps    = ucb_pkg::STEP_W'(22);
                    state_next   = ucb_pkg::ST_DIV_TERM;
                end
            end
            ucb_pkg::ST_DIV_TERM:
            begin
                if (!div_busy)
                begin
                    rad_next   = {div_q[21:0], 16'd0};
                    root_next  = '0;
                    bit_next   = ucb_pkg::RAD_W'(1) << 36;
                    state_next = ucb_pkg::ST_SQRT;
                end
            end
            ucb_pkg::ST_SQRT:
            begin
                if (rad_reg >= root_trial)
                begin
                    rad_next  = rad_reg - root_trial;
                    root_next = (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg[0])
                    state_next = ucb_pkg::ST_SCORE;
            end
            ucb_pkg::ST_SCORE:
            begin
                if ((idx_reg == '0) || (score > best_reg))
                begin
                    best_next     = score;
                    best_idx_next = idx_reg;
                end
                if (last_arm)
                begin
                    pend_arm_next   = ((idx_reg == '0) || (score > best_reg)) ? idx_reg
                                                                              : best_idx_reg;
                    pend_first_next = 1'b0;
                    state_next      = ucb_pkg::ST_OUT;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ucb_pkg::ST_ARM;
                end
            end
            ucb_pkg::ST_OUT:
            begin
                if (out_load)
                    state_next = ucb_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = ucb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ucb_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Working registers of the sequencer
    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        x_reg          <= x_next;
        top_reg        <= top_next;
        y_reg          <= y_next;
        frac_reg       <= frac_next;
        it_reg         <= it_next;
        ln_reg         <= ln_next;
        mean_reg       <= mean_next;
        rad_reg        <= rad_next;
        root_reg       <= root_next;
        bit_reg        <= bit_next;
        best_reg       <= best_next;
        best_idx_reg   <= best_idx_next;
        pend_arm_reg   <= pend_arm_next;
        pend_first_reg <= pend_first_next;
    end

    // Arm state: absorb update beats, saturate counts and sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ucb_pkg::NUM_ARMS; i++)
            begin
                pull_reg[i] <= '0;
                rsum_reg[i] <= '0;
            end
            total_reg <= '0;
        end
        else if (upd_fire)
        begin
            if (pull_reg[in_arm] != ucb_pkg::CNT_MAX)
                pull_reg[in_arm] <= pull_reg[in_arm] + 1'b1;
            if (rsum_reg[in_arm] > (ucb_pkg::SUM_MAX - {31'd0, rew_clamp}))
                rsum_reg[in_arm] <= ucb_pkg::SUM_MAX;
            else
                rsum_reg[in_arm] <= rsum_reg[in_arm] + {31'd0, rew_clamp};
            if (total_reg != ucb_pkg::CNT_MAX)
                total_reg <= total_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            arms_reg <= 5'd16;
        else if (cfg_valid && cfg_ready)
            arms_reg <= cfg_data;
    end

    // Output register: hold the beat until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (out_load)
            m_valid_reg <= 1'b1;
        else if (m_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            chosen_reg <= pend_arm_reg;
            first_reg  <= pend_first_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'd0, chosen_reg};
    assign m_tuser  = first_reg;

`ifndef SYNTHESIS
    a_div_in_div_states: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> (state_reg == ucb_pkg::ST_DIV_MEAN || state_reg == ucb_pkg::ST_DIV_TERM))
        else $error("divider busy outside a divide step");

    a_select_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && s_tuser == ucb_pkg::REQ_SELECT) |=> (state_reg == ucb_pkg::ST_SCAN))
        else $error("select beat did not start the scan");

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ucb_pkg::ST_SCAN || state_reg == ucb_pkg::ST_SCORE)
            |-> ({1'b0, idx_reg} < k_eff))
        else $error("arm index beyond arms in use");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && !m_tready) |-> !out_load)
        else $error("pending result overwritten");
`endif

endmodule

@@ tb/sv/ucb1_arm_selector_checker.sv @@
// ----------------------------------------------------------------------------
// UCB1 arm selector checker
// Watches the request, result and arm-count channels, predicts each selection
// from its own copy of the counts and sums, and compares result beats in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ucb1_arm_selector_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [4:0]  cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    input  logic        m_tuser,
    output int          fail_count,
    output int          pending_picks
);

    typedef struct packed {
        logic [ucb_pkg::ARM_W-1:0] arm;
        logic                      first_pass;
    } pick_t;

    logic [63:0] pulls [ucb_pkg::NUM_ARMS];
    logic [63:0] sums [ucb_pkg::NUM_ARMS];
    logic [63:0] grand_count;
    logic [4:0]  arm_reg;
    pick_t       pick_q[$];

    assign pending_picks = pick_q.size();

    function automatic int unsigned live_arms();
        int unsigned k;
        k = arm_reg;
        if (k == 0) k = 1;
        if (k > ucb_pkg::NUM_ARMS) k = ucb_pkg::NUM_ARMS;
        return k;
    endfunction

    function automatic logic [63:0] ln_fixed(logic [63:0] x);
        int unsigned top;
        logic [63:0] y, frac, l2;
        top = 0;
        frac = 0;
        if (x == 0) return 0;
        for (int i = 0; i < 64; i++)
            if (x[i]) top = i;
        y = (top >= 30) ? (x >> (top - 30)) : (x << (30 - top));
        for (int i = 0; i < 16; i++)
        begin
            y = (y * y) >> 30;
            frac = frac << 1;
            if (y >= (64'd2 << 30))
            begin
                y = y >> 1;
                frac[0] = 1'b1;
            end
        end
        l2 = (64'(top) << 16) | frac;
        return (l2 * 64'(ucb_pkg::LN2_Q16)) >> 16;
    endfunction

    function automatic logic [63:0] int_root(logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] ucb_score(int unsigned a, logic [63:0] lnt);
        logic [63:0] c, s;
        c = (pulls[a] == 0) ? 64'd1 : pulls[a];
        s = sums[a] / c + int_root(((64'd2 * lnt) / c) << 16);
        if (s > 64'(ucb_pkg::SCORE_MAX)) s = 64'(ucb_pkg::SCORE_MAX);
        return s;
    endfunction

    function automatic pick_t choose_arm();
        pick_t p;
        int unsigned k;
        logic [63:0] lnt, top_s, s;
        k = live_arms();
        for (int unsigned i = 0; i < k; i++)
            if (pulls[i] == 0)
            begin
                p.arm = ucb_pkg::ARM_W'(i);
                p.first_pass = 1'b1;
                return p;
            end
        lnt = ln_fixed(grand_count);
        p.arm = '0;
        p.first_pass = 1'b0;
        top_s = ucb_score(0, lnt);
        for (int unsigned i = 1; i < k; i++)
        begin
            s = ucb_score(i, lnt);
            if (s > top_s)
            begin
                top_s = s;
                p.arm = ucb_pkg::ARM_W'(i);
            end
        end
        return p;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pick_t want;
        logic [63:0] r;
        int unsigned a;
        if (!rst_n)
        begin
            for (int i = 0; i < ucb_pkg::NUM_ARMS; i++)
            begin
                pulls[i] = 0;
                sums[i] = 0;
            end
            grand_count = 0;
            arm_reg = 5'd16;
            fail_count = 0;
            pick_q.delete();
        end
        else
        begin
            // results first: a select cannot finish in the beat it is taken
            if (m_tvalid && m_tready)
            begin
                if (pick_q.size() == 0)
                begin
                    $error("unexpected result beat: chosen_arm %0d", m_tdata[3:0]);
                    fail_count++;
                end
                else
                begin
                    want = pick_q.pop_front();
                    if (m_tdata[3:0] !== want.arm)
                    begin
                        $error("chosen_arm expected %0d actual %0d", want.arm, m_tdata[3:0]);
                        fail_count++;
                    end
                    if (m_tuser !== want.first_pass)
                    begin
                        $error("from_first_pass expected %0d actual %0d",
                               want.first_pass, m_tuser);
                        fail_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                arm_reg = cfg_data;
            if (s_tvalid && s_tready)
            begin
                if (s_tuser == ucb_pkg::REQ_UPDATE)
                begin
                    a = s_tdata[3:0];
                    r = 64'(s_tdata[20:4]);
                    if (a < live_arms())
                    begin
                        if (r > 64'(ucb_pkg::REWARD_ONE)) r = 64'(ucb_pkg::REWARD_ONE);
                        if (pulls[a] < 64'(ucb_pkg::CNT_MAX)) pulls[a]++;
                        if (sums[a] > 64'(ucb_pkg::SUM_MAX) - r) sums[a] = 64'(ucb_pkg::SUM_MAX);
                        else sums[a] = sums[a] + r;
                        if (grand_count < 64'(ucb_pkg::CNT_MAX)) grand_count++;
                    end
                end
                else
                    pick_q.push_back(choose_arm());
            end
        end
    end

endmodule

@@ tb/sv/ucb1_arm_selector_tb.sv @@
// ----------------------------------------------------------------------------
// UCB1 arm selector testbench
// Drives select and update beats in bursts shaped like a bandit loop, moves
// the arm count between phases, and lets the checker judge every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ucb1_arm_selector_tb;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_BEATS   = 1500;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [4:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tuser;
    int          fail_count;
    int          pending_picks;

    // receiver controls: quiet_tail drops all idling, hold_off forces a long stall
    bit quiet_tail;
    bit hold_off;
    int idle_cycles;

    ucb1_arm_selector uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    ucb1_arm_selector_checker checker_i
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .fail_count    (fail_count),
        .pending_picks (pending_picks)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Receiver: random stall bursts, a long forced hold-off, none at the tail
    initial
    begin
        int burst;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
                m_tready <= 1'b0;
            else if (quiet_tail || $urandom_range(0, 3) != 0)
                m_tready <= 1'b1;
            else
            begin
                burst = $urandom_range(1, 18);
                m_tready <= 1'b0;
                repeat (burst - 1)
                begin
                    @(posedge clk);
                    if (quiet_tail) break;
                end
            end
        end
    end

    // Watchdog: count cycles with no beat accepted on any channel
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Offer one request beat and hold it until accepted
    task automatic send_beat(input logic kind, input logic [3:0] arm, input logic [16:0] rwd);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {3'b000, rwd, arm};
        do @(posedge clk); while (!(s_tvalid && s_tready));
    endtask

    // Sender gap: a random idle burst, lowering valid only when there is one
    task automatic sender_gap();
        int n;
        if (!quiet_tail && $urandom_range(0, 4) == 0)
        begin
            n = $urandom_range(1, 18);
            s_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic send_select();
        send_beat(ucb_pkg::REQ_SELECT, 4'($urandom), 17'($urandom));
        sender_gap();
    endtask

    task automatic send_update(input logic [3:0] arm, input logic [16:0] rwd);
        send_beat(ucb_pkg::REQ_UPDATE, arm, rwd);
        sender_gap();
    endtask

    // Reward biased toward the legal range, with some above one
    function automatic logic [16:0] pick_reward(input int unsigned bias);
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0) return 17'($urandom);
        if (r == 1) return ucb_pkg::REWARD_ONE;
        return 17'($urandom_range(0, bias));
    endfunction

    // Wait for every expected result, then let the block settle before a write
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_picks != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_arms(input logic [4:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int unsigned k, choice;
        int unsigned bias [16];
        int sent;
        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = ucb_pkg::REQ_SELECT;
        quiet_tail = 1'b0;
        hold_off   = 1'b0;
        idle_cycles = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: first pass from reset, extremes of reward, ignored arms
        send_select();
        send_update(4'd0, 17'd0);
        send_select();
        send_update(4'd1, ucb_pkg::REWARD_ONE);
        send_update(4'd2, 17'h1FFFF);
        send_select();
        write_arms(5'd0);
        send_update(4'd15, ucb_pkg::REWARD_ONE);
        send_update(4'd1, 17'd5);
        send_select();
        write_arms(5'd31);
        for (int i = 3; i < 16; i++)
            send_update(4'(i), 17'(i * 4000));
        send_select();
        send_select();
        write_arms(5'd3);
        send_update(4'd3, ucb_pkg::REWARD_ONE);
        send_select();
        write_arms(5'd1);
        send_select();

        // Random phases: mostly reward updates, some followed by a select, plus some noise
        sent = 0;
        while (sent < RANDOM_BEATS)
        begin
            choice = $urandom_range(0, 5);
            case (choice)
                0: k = 1;
                1: k = 16;
                default: k = $urandom_range(1, 6);
            endcase
            write_arms(5'(choice == 5 ? $urandom_range(0, 31) : k));
            k = (choice == 5) ? 16 : k;
            for (int i = 0; i < 16; i++)
                bias[i] = $urandom_range(0, 65536);
            if (sent > RANDOM_BEATS - 150) quiet_tail = 1'b1;
            repeat ($urandom_range(20, 60))
            begin
                if ($urandom_range(0, 3) != 0)
                begin
                    send_update(4'($urandom_range(0, k - 1)),
                                pick_reward(bias[$urandom_range(0, k - 1)]));
                    sent += 1;
                    if ($urandom_range(0, 2) == 0)
                    begin
                        send_select();
                        sent += 1;
                    end
                end
                else
                begin
                    if ($urandom_range(0, 1)) send_select();
                    else send_update(4'($urandom), 17'($urandom));
                    sent += 1;
                end
            end
            // Long receiver hold-off while selects keep arriving
            if (sent > 300 && sent < 420)
            begin
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (3000) @(posedge clk);
                        hold_off = 1'b0;
                    end
                    begin
                        repeat (4) send_select();
                    end
                join
            end
        end

        quiet_tail = 1'b1;
        drain();
        repeat (2000) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
